### sv/triangle_distance_rasterizer_macros.svh
// Assertion macros for the triangle distance rasterizer.
// No dependencies.
`ifndef TRIANGLE_DISTANCE_RASTERIZER_MACROS_SVH
`define TRIANGLE_DISTANCE_RASTERIZER_MACROS_SVH
// implication checked every cycle outside reset
`define TDR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the next cycle
`define TDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/tdr_pkg.sv
// Package for the triangle distance rasterizer: sizes, kind codes, types.
// No dependencies.
package tdr_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 4;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int COORD_W = 13;
  localparam int DIST_W  = 13;
  localparam int SIZE_W  = 9;
  localparam int SQ_W    = 2 * (COORD_W + 1);
  localparam int ROOT_W  = SQ_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [1:0] KIND_RASTER = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic signed [COORD_W+1:0] scoord_t;
  typedef logic signed [2*COORD_W+3:0] edge_t;
endpackage

### sv/tdr_sqrt.sv
// Iterative rounded square root, one result bit per cycle, saturated to DIST_W.
// Depends on tdr_pkg.
module tdr_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tdr_pkg::SQ_W-1:0]     radicand,
  output logic                         done,
  output logic [tdr_pkg::DIST_W-1:0]   root
);
  import tdr_pkg::*;

  logic [SQ_W-1:0]   rem;
  logic [SQ_W-1:0]   val;
  logic [ROOT_W-1:0] res;
  logic [$clog2(SQRT_STEPS+1)-1:0] step;
  logic busy;
  logic [SQ_W+1:0] trial;
  logic [SQ_W+1:0] rem_shift;
  logic [ROOT_W:0] rnd;

  assign rem_shift = {rem, val[SQ_W-1 -: 2]};
  assign trial = {{(SQ_W-ROOT_W){1'b0}}, res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        val  <= radicand;
        res  <= '0;
        step <= '0;
      end else if (busy) begin
        val <= {val[SQ_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
          rem <= SQ_W'(rem_shift - trial);
          res <= {res[ROOT_W-2:0], 1'b1};
        end else begin
          rem <= SQ_W'(rem_shift);
          res <= {res[ROOT_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == ($clog2(SQRT_STEPS+1))'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // rem = s - n*n; round up when rem > n
  assign rnd = ({1'b0, res} + ((rem > SQ_W'(res)) ? (ROOT_W+1)'(1) : '0));
  assign root = (rnd > (ROOT_W+1)'(DIST_MAX)) ? DIST_MAX : rnd[DIST_W-1:0];
endmodule

### sv/triangle_distance_rasterizer.sv
// Top level of the triangle distance rasterizer: sequencer, edge tests, store.
// Depends on tdr_pkg, tdr_sqrt and the assertion macros header.
// One request at a time. For a rasterize, out_valid rises after S_AREA, S_AREA2 and S_BOX,
// then S_PIX, S_EDGE and S_NEXT per bounding-box pixel outside the triangle (an inside
// pixel adds S_SQRT, S_WAIT and the bit-serial square root), an S_PIX step per box row,
// and a last S_PIX and S_DONE. A degenerate triangle raises out_valid after S_AREA, S_AREA2
// and S_DONE, a read after S_READ, S_READ2 and S_DONE, an unused kind after S_DONE. A clear
// raises out_valid at once, then sweeps all 65536 store entries, one entry per cycle, before
// the next request is taken. After reset the store is swept the same way before the first.
`include "triangle_distance_rasterizer_macros.svh"
module triangle_distance_rasterizer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [tdr_pkg::COORD_W-1:0] site_x,
  input  logic [tdr_pkg::COORD_W-1:0] site_y,
  input  logic [tdr_pkg::COORD_W-1:0] corner_a_x,
  input  logic [tdr_pkg::COORD_W-1:0] corner_a_y,
  input  logic [tdr_pkg::COORD_W-1:0] corner_b_x,
  input  logic [tdr_pkg::COORD_W-1:0] corner_b_y,
  input  logic [tdr_pkg::COL_W-1:0]   read_column,
  input  logic [tdr_pkg::ROW_W-1:0]   read_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tdr_pkg::DIST_W-1:0]  max_distance,
  output logic                        degenerate,
  output logic [tdr_pkg::DIST_W-1:0]  pixel_value,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tdr_pkg::SIZE_W-1:0]  cfg_data
);
  import tdr_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AREA, S_AREA2, S_BOX, S_PIX, S_EDGE, S_SQRT, S_WAIT,
    S_NEXT, S_READ, S_READ2, S_DONE
  } state_t;

  state_t state;
  logic [SIZE_W-1:0] surface_width, surface_height;
  logic [COL_W:0] w_sat;
  logic [ROW_W:0] h_sat;

  logic [DIST_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];
  logic [DIST_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [DIST_W-1:0] wr_data;

  scoord_t sx, sy, ax, ay, bx, by;
  logic [1:0] op;
  logic [COL_W-1:0] rcol;
  logic [ROW_W-1:0] rrow;
  logic [ADDR_W-1:0] sweep;
  edge_t p0, p1;
  edge_t e0a, e0b, e1a, e1b, e2a, e2b;
  logic [COORD_W-FRAC_BITS:0] x0, y0, x1, y1, px, py;
  scoord_t fx, fy, dx, dy;
  logic signed [SQ_W-1:0] dxw, dyw;
  logic [SQ_W-1:0] sq;
  logic sq_start, sq_done;
  logic [DIST_W-1:0] sq_root;
  logic [DIST_W-1:0] best;
  logic in_box;

  always_comb begin
    if (surface_width == '0) w_sat = (COL_W+1)'(1);
    else if (surface_width > SIZE_W'(MAX_WIDTH)) w_sat = (COL_W+1)'(MAX_WIDTH);
    else w_sat = (COL_W+1)'(surface_width);
    if (surface_height == '0) h_sat = (ROW_W+1)'(1);
    else if (surface_height > SIZE_W'(MAX_HEIGHT)) h_sat = (ROW_W+1)'(MAX_HEIGHT);
    else h_sat = (ROW_W+1)'(surface_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= SIZE_W'(256);
      surface_height <= SIZE_W'(256);
    end else if (cfg_we) begin
      if (cfg_index == REG_HEIGHT) surface_height <= cfg_data;
      else surface_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  tdr_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq),
    .done(sq_done), .root(sq_root)
  );

  function automatic scoord_t min3(scoord_t a, scoord_t b, scoord_t c);
    scoord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction
  function automatic scoord_t max3(scoord_t a, scoord_t b, scoord_t c);
    scoord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  assign fx = scoord_t'({px, {FRAC_BITS{1'b0}}});
  assign fy = scoord_t'({py, {FRAC_BITS{1'b0}}});
  assign dxw = SQ_W'(dx);
  assign dyw = SQ_W'(dy);
  assign in_box = (px <= x1);
  assign in_ready = (state == S_IDLE);
  assign rd_addr = {rrow, rcol};

  always_comb begin
    wr_en = 1'b0;
    wr_addr = {py[ROW_W-1:0], px[COL_W-1:0]};
    wr_data = sq_root;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = sweep;
      wr_data = '0;
    end else if (state == S_WAIT && sq_done) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      out_valid <= 1'b0;
      sq_start <= 1'b0;
    end else begin
      sq_start <= (state == S_SQRT);
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) state <= (op == KIND_CLEAR && out_valid) ? S_DONE : S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          op <= kind;
          sx <= scoord_t'(site_x); sy <= scoord_t'(site_y);
          ax <= scoord_t'(corner_a_x); ay <= scoord_t'(corner_a_y);
          bx <= scoord_t'(corner_b_x); by <= scoord_t'(corner_b_y);
          rcol <= read_column; rrow <= read_row;
          max_distance <= '0; degenerate <= 1'b0; pixel_value <= '0;
          best <= '0;
          case (kind)
            KIND_RASTER: state <= S_AREA;
            KIND_READ:   state <= S_READ;
            KIND_CLEAR: begin
              sweep <= '0;
              out_valid <= 1'b1;
              state <= S_CLEAR;
            end
            default: state <= S_DONE;
          endcase
          if (kind != KIND_CLEAR) out_valid <= 1'b0;
        end
        S_AREA: begin
          p0 <= (ax - sx) * (by - sy);
          p1 <= (ay - sy) * (bx - sx);
          state <= S_AREA2;
        end
        S_AREA2: begin
          if (p0 == p1) begin
            degenerate <= 1'b1;
            state <= S_DONE;
          end else state <= S_BOX;
        end
        S_BOX: begin
          x0 <= (COORD_W-FRAC_BITS+1)'(min3(sx, ax, bx) >>> FRAC_BITS);
          y0 <= (COORD_W-FRAC_BITS+1)'(min3(sy, ay, by) >>> FRAC_BITS);
          px <= (COORD_W-FRAC_BITS+1)'(min3(sx, ax, bx) >>> FRAC_BITS);
          py <= (COORD_W-FRAC_BITS+1)'(min3(sy, ay, by) >>> FRAC_BITS);
          x1 <= ((max3(sx, ax, bx) >>> FRAC_BITS) > scoord_t'(w_sat - 1'b1))
                ? (COORD_W-FRAC_BITS+1)'(w_sat - 1'b1)
                : (COORD_W-FRAC_BITS+1)'(max3(sx, ax, bx) >>> FRAC_BITS);
          y1 <= ((max3(sy, ay, by) >>> FRAC_BITS) > scoord_t'(h_sat - 1'b1))
                ? (COORD_W-FRAC_BITS+1)'(h_sat - 1'b1)
                : (COORD_W-FRAC_BITS+1)'(max3(sy, ay, by) >>> FRAC_BITS);
          state <= S_PIX;
        end
        S_PIX: begin
          if (py > y1) begin
            max_distance <= best;
            state <= S_DONE;
          end else if (!in_box) begin
            px <= x0;
            py <= py + 1'b1;
          end else begin
            e0a <= (bx - ax) * (fy - ay); e0b <= (by - ay) * (fx - ax);
            e1a <= (sx - bx) * (fy - by); e1b <= (sy - by) * (fx - bx);
            e2a <= (ax - sx) * (fy - sy); e2b <= (ay - sy) * (fx - sx);
            dx <= sx - fx; dy <= sy - fy;
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (e0a >= e0b && e1a >= e1b && e2a >= e2b) begin
            sq <= SQ_W'(dxw * dxw + dyw * dyw);
            state <= S_SQRT;
          end else state <= S_NEXT;
        end
        S_SQRT: state <= S_WAIT;
        S_WAIT: if (sq_done) begin
          if (sq_root > best) best <= sq_root;
          state <= S_NEXT;
        end
        S_NEXT: begin
          px <= px + 1'b1;
          state <= S_PIX;
        end
        S_READ: state <= S_READ2;
        S_READ2: begin
          if ({1'b0, rcol} < w_sat && {1'b0, rrow} < h_sat) pixel_value <= rd_data;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
    end
  end

  `TDR_ASSERT_IMPL(a_ready_idle, in_ready, !wr_en, "write while idle")
  `TDR_ASSERT_IMPL(a_one_result, out_valid && op == KIND_RASTER, pixel_value == '0,
    "pixel value on raster")
  `TDR_ASSERT_NEXT(a_sqrt_write, state == S_WAIT && sq_done, state == S_NEXT,
    "sqrt done lost")
endmodule

### verif/triangle_distance_rasterizer_test.sv
// Testbench for the triangle distance rasterizer: directed table, then random requests.
// Checked against an in-bench predictor or known row outcomes. Depends on tdr_pkg.
`timescale 1ns / 1ps
module triangle_distance_rasterizer_test;
  import tdr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 150;

  typedef struct {
    logic [1:0]  kind;
    logic [12:0] sx, sy, ax, ay, bx, by;
    logic [7:0]  col, row;
  } request_t;

  typedef struct {
    logic [12:0] max_distance;
    logic        degenerate;
    logic [12:0] pixel_value;
  } outcome_t;

  typedef struct {
    bit          set_size;
    logic [8:0]  w, h;
    request_t    req;
    bit          known;
    outcome_t    outc;
  } table_row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] kind = '0;
  logic [12:0] site_x = '0, site_y = '0, corner_a_x = '0, corner_a_y = '0;
  logic [12:0] corner_b_x = '0, corner_b_y = '0;
  logic [7:0] read_column = '0, read_row = '0;
  logic [12:0] max_distance, pixel_value;
  logic degenerate;
  logic cfg_we = 0, cfg_index = 0;
  logic [8:0] cfg_data = '0;

  triangle_distance_rasterizer DUT (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  logic [12:0] dist_store [MAX_WIDTH*MAX_HEIGHT];
  logic [8:0] width_reg = 9'd256, height_reg = 9'd256;
  outcome_t pending[$];
  int errors = 0;
  int results_seen = 0;
  int sent = 0;
  int last_col = 0, last_row = 0;

  function automatic longint orient(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  function automatic longint root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int used_size(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic outcome_t predict_distance(request_t r);
    outcome_t o;
    longint sx, sy, ax, ay, bx, by, x0, y0, x1, y1, fx, fy, dx, dy, n;
    longint unsigned sq;
    int w, h;
    o = '{0, 0, 0};
    w = used_size(width_reg);
    h = used_size(height_reg);
    case (r.kind)
      KIND_RASTER: begin
        sx = r.sx; sy = r.sy; ax = r.ax; ay = r.ay; bx = r.bx; by = r.by;
        if (orient(sx, sy, ax, ay, bx, by) == 0) begin
          o.degenerate = 1;
          return o;
        end
        x0 = ((sx < ax ? sx : ax) < bx ? (sx < ax ? sx : ax) : bx) >> FRAC_BITS;
        y0 = ((sy < ay ? sy : ay) < by ? (sy < ay ? sy : ay) : by) >> FRAC_BITS;
        x1 = ((sx > ax ? sx : ax) > bx ? (sx > ax ? sx : ax) : bx) >> FRAC_BITS;
        y1 = ((sy > ay ? sy : ay) > by ? (sy > ay ? sy : ay) : by) >> FRAC_BITS;
        if (x1 > w - 1) x1 = w - 1;
        if (y1 > h - 1) y1 = h - 1;
        for (longint py = y0; py <= y1; py++) begin
          for (longint px = x0; px <= x1; px++) begin
            fx = px << FRAC_BITS;
            fy = py << FRAC_BITS;
            if (orient(ax, ay, bx, by, fx, fy) >= 0 && orient(bx, by, sx, sy, fx, fy) >= 0
                && orient(sx, sy, ax, ay, fx, fy) >= 0) begin
              dx = sx - fx;
              dy = sy - fy;
              sq = dx * dx + dy * dy;
              n = root_floor(sq);
              if (sq > n * n + n) n++;
              if (n > 8191) n = 8191;
              dist_store[py * MAX_WIDTH + px] = n[12:0];
              if (n[12:0] > o.max_distance) o.max_distance = n[12:0];
            end
          end
        end
      end
      KIND_READ: begin
        if (r.col < w && r.row < h) o.pixel_value = dist_store[r.row * MAX_WIDTH + r.col];
      end
      KIND_CLEAR: begin
        foreach (dist_store[i]) dist_store[i] = '0;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_request(request_t r, bit known, outcome_t outc);
    outcome_t p;
    kind <= r.kind;
    site_x <= r.sx; site_y <= r.sy;
    corner_a_x <= r.ax; corner_a_y <= r.ay;
    corner_b_x <= r.bx; corner_b_y <= r.by;
    read_column <= r.col; read_row <= r.row;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_distance(r);
    pending.insert(pending.size(), known ? outc : p);
    sent++;
  endtask

  // drain, then write both size registers while the block sits idle
  task automatic set_surface(logic [8:0] w, logic [8:0] h);
    in_valid <= 0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
    cfg_we <= 1; cfg_index <= REG_WIDTH; cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT; cfg_data <= h;
    @(posedge clk);
    cfg_we <= 0;
    width_reg = w;
    height_reg = h;
  endtask

  function automatic request_t random_request();
    request_t r;
    int w, h, bxp, byp;
    w = used_size(width_reg);
    h = used_size(height_reg);
    r.kind = KIND_RASTER;
    r.col = 8'($urandom); r.row = 8'($urandom);
    r.sx = 0; r.sy = 0; r.ax = 0; r.ay = 0; r.bx = 0; r.by = 0;
    case ($urandom_range(0, 999)) inside
      [0:549]: begin
        if (w * h <= 256 && $urandom_range(0, 9) == 0) begin
          r.sx = 13'($urandom); r.sy = 13'($urandom); r.ax = 13'($urandom);
          r.ay = 13'($urandom); r.bx = 13'($urandom); r.by = 13'($urandom);
        end else begin
          bxp = $urandom_range(0, w + 1);
          byp = $urandom_range(0, h + 1);
          r.sx = 13'(bxp * 16 + $urandom_range(0, 96));
          r.sy = 13'(byp * 16 + $urandom_range(0, 96));
          r.ax = 13'(bxp * 16 + $urandom_range(0, 96));
          r.ay = 13'(byp * 16 + $urandom_range(0, 96));
          r.bx = 13'(bxp * 16 + $urandom_range(0, 96));
          r.by = 13'(byp * 16 + $urandom_range(0, 96));
          if ($urandom_range(0, 19) == 0) begin
            r.bx = r.ax; r.by = r.ay;
          end
        end
        last_col = int'(r.sx >> FRAC_BITS);
        last_row = int'(r.sy >> FRAC_BITS);
      end
      [550:947]: begin
        r.kind = KIND_READ;
        if ($urandom_range(0, 9) < 6) begin
          r.col = 8'(last_col + $urandom_range(0, 6) - 3);
          r.row = 8'(last_row + $urandom_range(0, 6) - 3);
        end
      end
      [948:997]: r.kind = KIND_UNUSED;
      default: r.kind = ($urandom_range(0, 2) == 0) ? KIND_CLEAR : KIND_READ;
    endcase
    return r;
  endfunction

  table_row_t directed[$];
  outcome_t zero_out = '{0, 0, 0};

  function automatic void add_row(table_row_t t);
    directed.insert(directed.size(), t);
  endfunction

  function automatic table_row_t row_of(logic [1:0] k, int sx, int sy, int ax, int ay,
                                        int bx, int by, int c, int rw, bit known,
                                        outcome_t o);
    table_row_t t;
    t.set_size = 0; t.w = 0; t.h = 0;
    t.req = '{k, 13'(sx), 13'(sy), 13'(ax), 13'(ay), 13'(bx), 13'(by), 8'(c), 8'(rw)};
    t.known = known;
    t.outc = o;
    return t;
  endfunction

  function automatic table_row_t size_row(logic [8:0] w, logic [8:0] h,
                                          table_row_t t);
    t.set_size = 1; t.w = w; t.h = h;
    return t;
  endfunction

  initial begin
    request_t r;
    foreach (dist_store[i]) dist_store[i] = '0;
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, zero_out));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 255, 255, 1, zero_out));
    add_row(row_of(KIND_UNUSED, 8191, 8191, 8191, 8191, 8191, 8191, 255, 255,
                   1, zero_out));
    add_row(row_of(KIND_RASTER, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 1, 0}));
    add_row(row_of(KIND_RASTER, 8191, 8191, 8191, 8191, 8191, 8191, 0, 0,
                   1, '{0, 1, 0}));
    add_row(row_of(KIND_RASTER, 16, 16, 160, 16, 16, 160, 0, 0, 0, zero_out));
    add_row(row_of(KIND_RASTER, 16, 16, 16, 160, 160, 16, 0, 0, 0, zero_out));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 3, 3, 0, zero_out));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 1, 1, 0, zero_out));
    add_row(row_of(KIND_RASTER, 4000, 4000, 4080, 4000, 4000, 4080, 0, 0,
                   0, zero_out));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 251, 251, 0, zero_out));
    add_row(row_of(KIND_CLEAR, 8191, 8191, 8191, 8191, 8191, 8191, 255, 255,
                   1, zero_out));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 3, 3, 1, zero_out));
    add_row(size_row(2, 2, row_of(KIND_RASTER, 8191, 8191, 0, 8191, 0, 0,
                                  0, 0, 0, zero_out)));
    add_row(row_of(KIND_RASTER, 8191, 8191, 0, 0, 0, 8191, 0, 0, 0, zero_out));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 1, 1, 0, zero_out));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 5, 0, 1, zero_out));
    add_row(row_of(KIND_RASTER, 100, 100, 200, 100, 100, 200, 0, 0, 1,
                   zero_out));
    add_row(size_row(0, 511, row_of(KIND_RASTER, 0, 0, 40, 4095, 0, 4095,
                                    0, 0, 0, zero_out)));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 255, 0, zero_out));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 1, 10, 1, zero_out));
    add_row(size_row(511, 0, row_of(KIND_RASTER, 0, 0, 4095, 0, 4095, 30,
                                    0, 0, 0, zero_out)));
    add_row(row_of(KIND_READ, 0, 0, 0, 0, 0, 0, 255, 0, 0, zero_out));

    repeat (12) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) begin
      if (directed[i].set_size) set_surface(directed[i].w, directed[i].h);
      send_request(directed[i].req, directed[i].known, directed[i].outc);
    end
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_surface(256, 256);
        1: set_surface(1, 1);
        2: set_surface(0, 0);
        3: set_surface(511, 511);
        default: set_surface(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = random_request();
        if (!(sent >= 400 && sent < 700) && $urandom_range(0, 99) < 8) begin
          in_valid <= 0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        send_request(r, 0, zero_out);
      end
    end
    in_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    outcome_t e;
    int hold;
    bit held;
    hold = 0;
    held = 0;
    out_ready <= 1;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          e = pending.pop_front();
          if (max_distance !== e.max_distance) begin
            $error("max_distance expected %0d actual %0d", e.max_distance, max_distance);
            errors++;
          end
          if (degenerate !== e.degenerate) begin
            $error("degenerate expected %0d actual %0d", e.degenerate, degenerate);
            errors++;
          end
          if (pixel_value !== e.pixel_value) begin
            $error("pixel_value expected %0d actual %0d", e.pixel_value, pixel_value);
            errors++;
          end
        end
        results_seen++;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (results_seen == 900 && !held) begin
        held = 1;
        hold = 2000;
        out_ready <= 0;
      end else begin
        out_ready <= (results_seen >= 400 && results_seen < 700) || $urandom_range(0, 99) >= 8;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/tdr_pkg.sv
sv/tdr_sqrt.sv
sv/triangle_distance_rasterizer.sv
verif/triangle_distance_rasterizer_test.sv
